// ===== hw/rtl/mwmn_pkg.sv =====
// Shared constants and types for the mecanum wheel mixer.
package mwmn_pkg;

   localparam int WHEEL_COUNT   = 4;
   localparam int WHEEL_LIMIT   = 512;
   localparam int OUT_BITS      = 11;
   // quotient never exceeds the limit, so it needs log2(limit)+1 bits
   localparam int QUOT_BITS     = $clog2(WHEEL_LIMIT) + 1;
   localparam int RSP_DATA_BITS = ((WHEEL_COUNT * OUT_BITS + 7) / 8) * 8;

   // Per-item side information carried alongside the divider
   typedef struct packed {
      logic                                 bypass;  // peak within limit, pass sums
      logic [WHEEL_COUNT-1:0]               neg;     // sign of each wheel sum
      logic [WHEEL_COUNT-1:0][OUT_BITS-1:0] raw;     // unscaled sums, output width
   } wheel_info_type;

endpackage

// ===== hw/rtl/mwmn_mix.sv =====
// Wheel sums, magnitudes and peak search: two register stages.
module mwmn_mix
   import mwmn_pkg::*;
#(
   parameter int COMMAND_BITS = 12,
   parameter int MAG_BITS     = COMMAND_BITS + 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    in_valid,
   input  logic signed [COMMAND_BITS-1:0]          fwd,
   input  logic signed [COMMAND_BITS-1:0]          side,
   input  logic signed [COMMAND_BITS-1:0]          turn,
   output logic                                    out_valid,
   output logic [WHEEL_COUNT-1:0][MAG_BITS-1:0]    mag,
   output logic [MAG_BITS-1:0]                     peak,
   output wheel_info_type                          info
);

   localparam int SUM_BITS = COMMAND_BITS + 2;

   logic signed [SUM_BITS-1:0] sum_ff [WHEEL_COUNT];
   logic signed [SUM_BITS-1:0] sum_in [WHEEL_COUNT];
   logic                       sum_valid_ff;

   logic [WHEEL_COUNT-1:0][MAG_BITS-1:0] mag_ff, mag_in;
   logic [MAG_BITS-1:0]                  peak_ff, peak_in;
   logic [MAG_BITS-1:0]                  peak_a, peak_b;
   wheel_info_type                       info_ff, info_in;
   logic                                 mag_valid_ff;

   logic signed [SUM_BITS-1:0] fwd_x, side_x, turn_x;

   always_comb begin
      fwd_x     = SUM_BITS'(fwd);
      side_x    = SUM_BITS'(side);
      turn_x    = SUM_BITS'(turn);
      sum_in[0] = fwd_x + side_x + turn_x;
      sum_in[1] = fwd_x - side_x - turn_x;
      sum_in[2] = fwd_x - side_x + turn_x;
      sum_in[3] = fwd_x + side_x - turn_x;
   end

   always_comb begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         info_in.neg[i] = sum_ff[i][SUM_BITS-1];
         info_in.raw[i] = OUT_BITS'(sum_ff[i]);
         if (sum_ff[i][SUM_BITS-1]) begin
            mag_in[i] = MAG_BITS'(-sum_ff[i]);
         end else begin
            mag_in[i] = MAG_BITS'(sum_ff[i]);
         end
      end
      peak_a = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
      peak_b = (mag_in[2] > mag_in[3]) ? mag_in[2] : mag_in[3];
      peak_in = (peak_a > peak_b) ? peak_a : peak_b;
      info_in.bypass = ({{(32-MAG_BITS){1'b0}}, peak_in} <= 32'(WHEEL_LIMIT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         mag_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= in_valid;
         mag_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff  <= sum_in;
         mag_ff  <= mag_in;
         peak_ff <= peak_in;
         info_ff <= info_in;
      end
   end

   assign out_valid = mag_valid_ff;
   assign mag       = mag_ff;
   assign peak      = peak_ff;
   assign info      = info_ff;

endmodule

// ===== hw/rtl/mwmn_div_step.sv =====
// One restoring-division step for all four wheels, one quotient bit per stage.
module mwmn_div_step
   import mwmn_pkg::*;
#(
   parameter int MAG_BITS   = 13,
   parameter int FIRST_STEP = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic [MAG_BITS-1:0]                   in_peak,
   input  logic [WHEEL_COUNT-1:0][MAG_BITS-1:0]  in_rem,
   input  logic [WHEEL_COUNT-1:0][QUOT_BITS-1:0] in_quot,
   input  wheel_info_type                        in_info,
   output logic                                  out_valid,
   output logic [MAG_BITS-1:0]                   out_peak,
   output logic [WHEEL_COUNT-1:0][MAG_BITS-1:0]  out_rem,
   output logic [WHEEL_COUNT-1:0][QUOT_BITS-1:0] out_quot,
   output wheel_info_type                        out_info
);

   logic                                  valid_ff;
   logic [MAG_BITS-1:0]                   peak_ff;
   logic [WHEEL_COUNT-1:0][MAG_BITS-1:0]  rem_ff, rem_in;
   logic [WHEEL_COUNT-1:0][QUOT_BITS-1:0] quot_ff, quot_in;
   wheel_info_type                        info_ff;

   logic [MAG_BITS:0] trial [WHEEL_COUNT];
   logic [MAG_BITS:0] diff  [WHEEL_COUNT];
   logic              take  [WHEEL_COUNT];

   always_comb begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         // first step starts from the magnitude itself, later ones shift in a zero
         if (FIRST_STEP != 0) begin
            trial[i] = {1'b0, in_rem[i]};
         end else begin
            trial[i] = {in_rem[i], 1'b0};
         end
         diff[i]    = trial[i] - {1'b0, in_peak};
         take[i]    = (trial[i] >= {1'b0, in_peak});
         rem_in[i]  = take[i] ? diff[i][MAG_BITS-1:0] : trial[i][MAG_BITS-1:0];
         quot_in[i] = {in_quot[i][QUOT_BITS-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         peak_ff <= in_peak;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         info_ff <= in_info;
      end
   end

   assign out_valid = valid_ff;
   assign out_peak  = peak_ff;
   assign out_rem   = rem_ff;
   assign out_quot  = quot_ff;
   assign out_info  = info_ff;

endmodule

// ===== hw/rtl/mecanum_wheel_mix_normalize.sv =====
// Mecanum wheel mixer top level: mix, pipelined normalizing divider, output register.
// Path from an accepted req item to rsp_tvalid: 2 mix stages, one stage per
// quotient bit of the 10-bit divider, 1 output stage.
// Throughput: one item per cycle; the whole pipeline holds while rsp is stalled.
// Reset clears all valid bits; payload registers are not reset.
module mecanum_wheel_mix_normalize
   import mwmn_pkg::*;
#(
   parameter int COMMAND_BITS = 12
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // speed_forward, speed_sideways, turn_rate (low bit up), zero pad
   input  logic [((3*COMMAND_BITS+7)/8)*8-1:0]        req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // wheel_front_left, wheel_front_right, wheel_rear_left, wheel_rear_right, zero pad
   output logic [RSP_DATA_BITS-1:0]                   rsp_tdata
);

   localparam int MAG_BITS = COMMAND_BITS + 1;

   logic advance;

   logic                                  valid_c [QUOT_BITS+1];
   logic [MAG_BITS-1:0]                   peak_c  [QUOT_BITS+1];
   logic [WHEEL_COUNT-1:0][MAG_BITS-1:0]  rem_c   [QUOT_BITS+1];
   logic [WHEEL_COUNT-1:0][QUOT_BITS-1:0] quot_c  [QUOT_BITS+1];
   wheel_info_type                        info_c  [QUOT_BITS+1];

   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // hold every stage while a finished item waits at the output
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   mwmn_mix #(
      .COMMAND_BITS (COMMAND_BITS),
      .MAG_BITS     (MAG_BITS)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .fwd       (req_tdata[COMMAND_BITS-1:0]),
      .side      (req_tdata[2*COMMAND_BITS-1:COMMAND_BITS]),
      .turn      (req_tdata[3*COMMAND_BITS-1:2*COMMAND_BITS]),
      .out_valid (valid_c[0]),
      .mag       (rem_c[0]),
      .peak      (peak_c[0]),
      .info      (info_c[0])
   );

   assign quot_c[0] = '0;

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
      mwmn_div_step #(
         .MAG_BITS   (MAG_BITS),
         .FIRST_STEP ((k == 0) ? 1 : 0)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_c[k]),
         .in_peak   (peak_c[k]),
         .in_rem    (rem_c[k]),
         .in_quot   (quot_c[k]),
         .in_info   (info_c[k]),
         .out_valid (valid_c[k+1]),
         .out_peak  (peak_c[k+1]),
         .out_rem   (rem_c[k+1]),
         .out_quot  (quot_c[k+1]),
         .out_info  (info_c[k+1])
      );
   end

   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         if (info_c[QUOT_BITS].bypass) begin
            rsp_data_in[i*OUT_BITS +: OUT_BITS] = info_c[QUOT_BITS].raw[i];
         end else if (info_c[QUOT_BITS].neg[i]) begin
            rsp_data_in[i*OUT_BITS +: OUT_BITS] =
               -{{(OUT_BITS-QUOT_BITS){1'b0}}, quot_c[QUOT_BITS][i]};
         end else begin
            rsp_data_in[i*OUT_BITS +: OUT_BITS] =
               {{(OUT_BITS-QUOT_BITS){1'b0}}, quot_c[QUOT_BITS][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_c[QUOT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/sv/mecanum_wheel_mix_normalize_tb.sv =====
// Self-checking testbench for the mecanum wheel mixer with peak normalization.
module mecanum_wheel_mix_normalize_tb
   import mwmn_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COMMAND_BITS  = 12;
   localparam int REQ_BITS      = ((3*COMMAND_BITS+7)/8)*8;
   localparam int PIPE_LATENCY  = 13;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int CYCLE_LIMIT   = 400000;

   typedef logic [COMMAND_BITS-1:0] command_type;
   typedef logic [WHEEL_COUNT-1:0][OUT_BITS-1:0] wheel_set_type;

   // Holds predicted wheel sets in order and checks each result against the oldest.
   class wheel_scoreboard;
      wheel_set_type wheels_due[$];
      int            errors;
      int            commands;
      int            scaled;
      int            checked;
      string         wheel_name[WHEEL_COUNT] = '{"wheel_front_left", "wheel_front_right",
                                                 "wheel_rear_left", "wheel_rear_right"};

      function wheel_set_type mix_and_normalize(command_type fwd_raw, command_type side_raw,
                                                command_type turn_raw);
         int            fwd, side, turn, peak;
         int            sum[WHEEL_COUNT];
         wheel_set_type result;
         fwd  = $signed(fwd_raw);
         side = $signed(side_raw);
         turn = $signed(turn_raw);
         sum[0] = fwd + side + turn;
         sum[1] = fwd - side - turn;
         sum[2] = fwd - side + turn;
         sum[3] = fwd + side - turn;
         peak = 0;
         foreach (sum[i]) begin
            if ((sum[i] < 0 ? -sum[i] : sum[i]) > peak) begin
               peak = sum[i] < 0 ? -sum[i] : sum[i];
            end
         end
         if (peak > WHEEL_LIMIT) begin
            scaled++;
            // int division truncates toward zero, as the scaling requires
            foreach (sum[i]) sum[i] = (sum[i] * WHEEL_LIMIT) / peak;
         end
         foreach (sum[i]) result[i] = OUT_BITS'(sum[i]);
         return result;
      endfunction

      function void note_command(logic [REQ_BITS-1:0] data);
         commands++;
         wheels_due.push_back(mix_and_normalize(data[COMMAND_BITS-1:0],
                                                data[2*COMMAND_BITS-1:COMMAND_BITS],
                                                data[3*COMMAND_BITS-1:2*COMMAND_BITS]));
      endfunction

      function void check_wheels(logic [RSP_DATA_BITS-1:0] data);
         wheel_set_type want;
         wheel_set_type got;
         got = data[WHEEL_COUNT*OUT_BITS-1:0];
         if (wheels_due.size() == 0) begin
            $error("wheel item with no command pending: %h", data);
            errors++;
            return;
         end
         want = wheels_due.pop_front();
         checked++;
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            if (got[i] !== want[i]) begin
               $error("%s mismatch: expected %0d, actual %0d", wheel_name[i],
                      $signed(want[i]), $signed(got[i]));
               errors++;
            end
         end
      endfunction

      function int pending();
         return wheels_due.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   wheel_scoreboard board = new();
   bit  source_steady = 1'b0;
   bit  sink_steady   = 1'b0;
   int  stall_left    = 0;
   int  cycle_count   = 0;

   mecanum_wheel_mix_normalize #(.COMMAND_BITS(COMMAND_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_command(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_wheels(rsp_tdata);
   end

   // Result side: mostly ready, short drops, now and then a long stall.
   always @(posedge clock) begin : sink_drive
      int roll;
      roll = $urandom_range(0, 99);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (sink_steady) begin
         rsp_tready <= 1'b1;
      end else if (roll < 65) begin
         rsp_tready <= 1'b1;
      end else if (roll < 96) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(10, 40);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (source_steady || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Offer one command, hold it until accepted, then idle for a random gap.
   task automatic send_command(int fwd, int side, int turn);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'({command_type'(turn), command_type'(side),
                               command_type'(fwd)});
      do @(posedge clock); while (!req_tready);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int pick_extreme();
      int pool[8] = '{-2048, 2047, -1, 0, 1, 512, -512, 1365};
      return pool[$urandom_range(0, 7)];
   endfunction

   task automatic send_random_command();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            send_command($urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095));
         end
         4, 5, 6: begin
            // always stay within the unscaled region
            send_command(int'($urandom_range(0, 340)) - 170, int'($urandom_range(0, 340)) - 170,
                         int'($urandom_range(0, 340)) - 170);
         end
         7: begin
            // peak lands close to the limit on either side
            send_command(int'($urandom_range(0, 80)) + 470, int'($urandom_range(0, 20)) - 10,
                         int'($urandom_range(0, 20)) - 10);
         end
         8: begin
            send_command(pick_extreme(), pick_extreme(), pick_extreme());
         end
         default: begin
            case ($urandom_range(0, 2))
               0: send_command($urandom_range(0, 4095), 0, 0);
               1: send_command(0, $urandom_range(0, 4095), 0);
               default: send_command(0, 0, $urandom_range(0, 4095));
            endcase
         end
      endcase
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: zero, extremes, limit boundary, single axes
      send_command(0, 0, 0);
      send_command(2047, 2047, 2047);
      send_command(-2048, -2048, -2048);
      send_command(2047, -2048, 2047);
      send_command(-2048, 2047, -2048);
      send_command(512, 0, 0);
      send_command(513, 0, 0);
      send_command(0, -512, 0);
      send_command(0, 0, -513);
      send_command(170, 171, 171);
      send_command(171, 171, 171);
      send_command(100, -50, 30);
      send_command(-300, 100, -100);
      send_command(2047, 0, 0);
      send_command(0, 2047, 0);
      send_command(0, 0, -2048);
      send_command(-2048, 0, 0);
      send_command(1, 0, 0);
      send_command(-1, 0, 0);
      send_command(1000, -999, 1);
      send_command(7, -3, 5);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // switch back-pressure and gap behavior every so often
         if (n % 150 == 0) begin
            source_steady = ($urandom_range(0, 2) == 0);
            sink_steady   = ($urandom_range(0, 2) == 0);
         end
         send_random_command();
      end
      req_tvalid <= 1'b0;
      sink_steady = 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (2*PIPE_LATENCY) @(posedge clock);

      $display("Ran %0d drive commands, %0d needed scaling; %0d wheel sets checked.",
               board.commands, board.scaled, board.checked);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mwmn_pkg.sv
hw/rtl/mwmn_mix.sv
hw/rtl/mwmn_div_step.sv
hw/rtl/mecanum_wheel_mix_normalize.sv
tb/sv/mecanum_wheel_mix_normalize_tb.sv
